@@ rtl/tac_pkg.sv @@
package tac_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAME_W     = 16;
    localparam int FRAME_SHIFT = 3;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 4;
    localparam int N_W         = CNT_W + 1;
    localparam int SIZE_W      = 11;
    localparam int OUT_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIV_W       = SAMPLE_BITS + SIZE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam logic [FRAME_W-1:0] SAMPLE_MASK = FRAME_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [OUT_W-1:0]   OUT_MAX     = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_RAW_LOW     = 3'd0,
        REG_X_RAW_HIGH    = 3'd1,
        REG_Y_RAW_LOW     = 3'd2,
        REG_Y_RAW_HIGH    = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_SAMPLES       = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [11:0]       x_raw_low;
        logic [11:0]       x_raw_high;
        logic [11:0]       y_raw_low;
        logic [11:0]       y_raw_high;
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
        logic [CNT_W-1:0]  samples_per_point;
    } t_cfg;

    // one finished point: raw sums and how many samples went in
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [N_W-1:0]   n;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL,
        ST_SCALE,
        ST_DONE
    } t_back_state;

endpackage

@@ rtl/tac_div.sv @@
module tac_div
    import tac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [11:0]      i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quotient
);

    logic [11:0]          r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [11:0]          r_dvs;

    logic [12:0] rem_shift;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {r_rem, r_quo[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? 12'(rem_shift - {1'b0, r_dvs}) : rem_shift[11:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

@@ rtl/tac_front.sv @@
module tac_front
    import tac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [FRAME_W-1:0] i_x_frame,
    input  logic [FRAME_W-1:0] i_y_frame,
    input  logic [CNT_W-1:0]   i_samples_per_point,
    input  logic               i_q_full,
    output logic               o_full,
    output logic               o_q_push,
    output t_point             o_q_data
);

    logic [SUM_W-1:0] r_sum_x, n_sum_x;
    logic [SUM_W-1:0] r_sum_y, n_sum_y;
    logic [CNT_W-1:0] r_count;

    logic [FRAME_W-1:0] smp_x, smp_y;
    logic [N_W-1:0]     n_cnt, target;
    logic               accept, last;

    assign smp_x  = (i_x_frame >> FRAME_SHIFT) & SAMPLE_MASK;
    assign smp_y  = (i_y_frame >> FRAME_SHIFT) & SAMPLE_MASK;
    assign n_sum_x = r_sum_x + SUM_W'(smp_x);
    assign n_sum_y = r_sum_y + SUM_W'(smp_y);
    assign n_cnt   = {1'b0, r_count} + 1'b1;
    // zero samples per point acts as one
    assign target  = (i_samples_per_point == '0) ? N_W'(1) : {1'b0, i_samples_per_point};
    assign last    = n_cnt >= target;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (last) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_count <= n_cnt[CNT_W-1:0];
            end
        end
    end

    assign o_q_push       = accept && last;
    assign o_q_data.sum_x = n_sum_x;
    assign o_q_data.sum_y = n_sum_y;
    assign o_q_data.n     = n_cnt;

endmodule

@@ rtl/tac_back.sv @@
module tac_back
    import tac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_point           i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [OUT_W-1:0] o_pixel_col,
    output logic [OUT_W-1:0] o_pixel_row
);

    t_back_state r_state, n_state;

    logic [11:0]      r_diff_x, r_diff_y;
    logic [OUT_W-1:0] r_col, r_row;
    logic [OUT_W-1:0] r_res_col, r_res_row;
    logic             r_out_valid;

    logic             div_start;
    logic [DIV_W-1:0] dvd_x, dvd_y;
    logic [11:0]      dvs_x, dvs_y;
    logic             busy_x, busy_y;
    logic [DIV_W-1:0] quo_x, quo_y;

    logic [11:0]       span_x, span_y;
    logic              ok_x, ok_y;
    logic [SIZE_W-1:0] size_w, size_h;
    logic [SIZE_W-1:0] lim_col, lim_row;
    logic [11:0]       cl_x, cl_y;
    logic [OUT_W-1:0]  sat_col, sat_row;
    logic              load_diff, load_res, load_out;

    assign ok_x   = i_cfg.x_raw_high > i_cfg.x_raw_low;
    assign ok_y   = i_cfg.y_raw_high > i_cfg.y_raw_low;
    assign span_x = i_cfg.x_raw_high - i_cfg.x_raw_low;
    assign span_y = i_cfg.y_raw_high - i_cfg.y_raw_low;
    assign size_w = (i_cfg.screen_width == '0) ? SIZE_W'(1) : i_cfg.screen_width;
    assign size_h = (i_cfg.screen_height == '0) ? SIZE_W'(1) : i_cfg.screen_height;
    assign lim_col = size_w - 1'b1;
    assign lim_row = size_h - 1'b1;

    // averages are exact below 2^16, compare at full quotient width
    function automatic logic [11:0] clamp(input logic [DIV_W-1:0] v,
                                          input logic [11:0] lo,
                                          input logic [11:0] hi);
        logic [11:0] c;
        if (v < DIV_W'(lo)) begin
            c = lo;
        end else if (v > DIV_W'(hi)) begin
            c = hi;
        end else begin
            c = v[11:0];
        end
        return c;
    endfunction

    function automatic logic [OUT_W-1:0] sat(input logic [DIV_W-1:0] p,
                                             input logic [SIZE_W-1:0] lim);
        logic [DIV_W-1:0] q;
        q = (p > DIV_W'(lim)) ? DIV_W'(lim) : p;
        return (q > DIV_W'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
    endfunction

    assign cl_x    = clamp(quo_x, i_cfg.x_raw_low, i_cfg.x_raw_high);
    assign cl_y    = clamp(quo_y, i_cfg.y_raw_low, i_cfg.y_raw_high);
    assign sat_col = ok_y ? sat(quo_y, lim_col) : '0;
    assign sat_row = ok_x ? sat(quo_x, lim_row) : '0;

    // first pass divides sums by count, second pass divides scaled offset by span
    always_comb begin
        if (r_state == ST_IDLE) begin
            dvd_x = DIV_W'(i_q_data.sum_x);
            dvd_y = DIV_W'(i_q_data.sum_y);
            dvs_x = 12'(i_q_data.n);
            dvs_y = 12'(i_q_data.n);
        end else begin
            dvd_x = DIV_W'(r_diff_x) * DIV_W'(size_h);
            dvd_y = DIV_W'(r_diff_y) * DIV_W'(size_w);
            dvs_x = span_x;
            dvs_y = span_y;
        end
    end

    tac_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_x),
        .i_divisor  (dvs_x),
        .o_busy     (busy_x),
        .o_quotient (quo_x)
    );

    tac_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_y),
        .i_divisor  (dvs_y),
        .o_busy     (busy_y),
        .o_quotient (quo_y)
    );

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        o_q_pop   = 1'b0;
        load_diff = 1'b0;
        load_res  = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    div_start = 1'b1;
                    n_state   = ST_AVG;
                end
            end
            ST_AVG: begin
                if (!busy_x && !busy_y) begin
                    load_diff = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                div_start = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                if (!busy_x && !busy_y) begin
                    load_res = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_diff) begin
            r_diff_x <= cl_x - i_cfg.x_raw_low;
            r_diff_y <= cl_y - i_cfg.y_raw_low;
        end
        if (load_res) begin
            r_res_col <= sat_col;
            r_res_row <= sat_row;
        end
        if (load_out) begin
            r_col <= r_res_col;
            r_row <= r_res_row;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_pixel_col = r_col;
    assign o_pixel_row = r_row;

endmodule

@@ rtl/touch_average_calibrate.sv @@
// path: a beat that does not finish a point only adds to the sums and gives no result;
//   a finishing beat goes through the point queue and two 23-step shift-subtract divider
//   passes (average, then scaling); a result not yet popped holds the next one back
// throughput: one input beat per cycle while the point queue has room; the back end
//   takes one point at a time, the two-entry queue absorbs bursts
// reset: synchronous active-low i_rst_n clears sums, count, queue, output; loads defaults
module touch_average_calibrate
    import tac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input queue side
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [FRAME_W-1:0]    i_x_frame,
    input  logic [FRAME_W-1:0]    i_y_frame,
    // result queue side
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [OUT_W-1:0]      o_pixel_col,
    output logic [OUT_W-1:0]      o_pixel_row,
    // register write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    // point queue between front and back
    t_point     r_q_mem [2];
    logic       r_q_wr, r_q_rd;
    logic [1:0] r_q_cnt;

    logic   q_push, q_pop, q_full, q_valid;
    t_point q_wdata;

    // register file, writes always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_raw_low         <= 12'd0;
            r_cfg.x_raw_high        <= 12'd4095;
            r_cfg.y_raw_low         <= 12'd0;
            r_cfg.y_raw_high        <= 12'd4095;
            r_cfg.screen_width      <= SIZE_W'(240);
            r_cfg.screen_height     <= SIZE_W'(320);
            r_cfg.samples_per_point <= CNT_W'(5);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_RAW_LOW:     r_cfg.x_raw_low         <= i_cfg_data;
                REG_X_RAW_HIGH:    r_cfg.x_raw_high        <= i_cfg_data;
                REG_Y_RAW_LOW:     r_cfg.y_raw_low         <= i_cfg_data;
                REG_Y_RAW_HIGH:    r_cfg.y_raw_high        <= i_cfg_data;
                REG_SCREEN_WIDTH:  r_cfg.screen_width      <= i_cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height     <= i_cfg_data[SIZE_W-1:0];
                REG_SAMPLES:       r_cfg.samples_per_point <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: sample extraction and accumulation
    tac_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (i_push),
        .i_x_frame           (i_x_frame),
        .i_y_frame           (i_y_frame),
        .i_samples_per_point (r_cfg.samples_per_point),
        .i_q_full            (q_full),
        .o_full              (o_full),
        .o_q_push            (q_push),
        .o_q_data            (q_wdata)
    );

    assign q_full  = r_q_cnt == 2'd2;
    assign q_valid = r_q_cnt != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= 1'b0;
            r_q_rd  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wr <= ~r_q_wr;
            end
            if (q_pop) begin
                r_q_rd <= ~r_q_rd;
            end
            if (q_push && !q_pop) begin
                r_q_cnt <= r_q_cnt + 1'b1;
            end else if (!q_push && q_pop) begin
                r_q_cnt <= r_q_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_mem[r_q_wr] <= q_wdata;
        end
    end

    // back: average, clamp, scale, saturate, hold result beat
    tac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (r_q_mem[r_q_rd]),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row)
    );

endmodule
